// ===== design/gps_pkg.sv =====
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types and constants of the 8-pin GPIO port with pin sensing.
// ----------------------------------------------------------------------------
package gps_pkg;

    // Bus register offsets
    localparam logic [15:0] OFS_DIRTGL   = 16'h0003;
    localparam logic [15:0] OFS_OUTTGL   = 16'h0007;
    localparam logic [15:0] OFS_IN       = 16'h0008;
    localparam logic [15:0] OFS_FLAGS    = 16'h0009;
    localparam logic [15:0] OFS_PORTCTRL = 16'h000A;
    localparam logic [15:0] OFS_PIN0     = 16'h0010;
    localparam logic [15:0] OFS_PIN7     = 16'h0017;

    // Reset value of the base address register
    localparam logic [15:0] BASE_RESET = 16'h0400;

    // Transaction opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PIN   = 2'd2;

    // Pin control fields
    localparam int unsigned PULLUP_BIT = 3;
    localparam logic [2:0] SENSE_BOTH    = 3'd1;
    localparam logic [2:0] SENSE_RISING  = 3'd2;
    localparam logic [2:0] SENSE_FALLING = 3'd3;
    localparam logic [2:0] SENSE_LOW     = 3'd5;

    // Register selected by a bus offset
    typedef enum logic [3:0] {
        SEL_DIR,
        SEL_DIRSET,
        SEL_DIRCLR,
        SEL_DIRTGL,
        SEL_OUT,
        SEL_OUTSET,
        SEL_OUTCLR,
        SEL_OUTTGL,
        SEL_IN,
        SEL_FLAGS,
        SEL_PORTCTRL,
        SEL_PINCTRL,
        SEL_NONE
    } reg_sel_t;

    typedef struct packed {
        reg_sel_t   sel;
        logic [2:0] pin;
    } dec_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic [2:0]  pin_index;
        logic        pin_level;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] drive_value;
        logic [7:0] direction_mask;
        logic [7:0] pullup_mask;
        logic       irq;
        logic       access_error;
    } out_item_t;

endpackage

// ===== design/gps_decode.sv =====
// ----------------------------------------------------------------------------
// gps_decode
// Maps a bus address to a port register, relative to the base address.
// ----------------------------------------------------------------------------
module gps_decode (
    input  logic [15:0]   base_address,
    input  logic [15:0]   bus_address,
    output gps_pkg::dec_t dec
);

    logic [15:0] ofs;

    // Offset wraps modulo 2^16
    assign ofs = bus_address - base_address;

    always_comb
    begin
        dec.pin = ofs[2:0];
        if (ofs <= gps_pkg::OFS_DIRTGL)
        begin
            case (ofs[1:0])
                2'd0:    dec.sel = gps_pkg::SEL_DIR;
                2'd1:    dec.sel = gps_pkg::SEL_DIRSET;
                2'd2:    dec.sel = gps_pkg::SEL_DIRCLR;
                default: dec.sel = gps_pkg::SEL_DIRTGL;
            endcase
        end
        else if (ofs <= gps_pkg::OFS_OUTTGL)
        begin
            case (ofs[1:0])
                2'd0:    dec.sel = gps_pkg::SEL_OUT;
                2'd1:    dec.sel = gps_pkg::SEL_OUTSET;
                2'd2:    dec.sel = gps_pkg::SEL_OUTCLR;
                default: dec.sel = gps_pkg::SEL_OUTTGL;
            endcase
        end
        else if (ofs == gps_pkg::OFS_IN)
            dec.sel = gps_pkg::SEL_IN;
        else if (ofs == gps_pkg::OFS_FLAGS)
            dec.sel = gps_pkg::SEL_FLAGS;
        else if (ofs == gps_pkg::OFS_PORTCTRL)
            dec.sel = gps_pkg::SEL_PORTCTRL;
        else if (ofs >= gps_pkg::OFS_PIN0 && ofs <= gps_pkg::OFS_PIN7)
            dec.sel = gps_pkg::SEL_PINCTRL;
        else
            dec.sel = gps_pkg::SEL_NONE;
    end

endmodule

// ===== design/gps_regs.sv =====
// ----------------------------------------------------------------------------
// gps_regs
// Port register file: bus reads and writes, pin change sensing, result.
// ----------------------------------------------------------------------------
module gps_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  gps_pkg::in_item_t  item,
    input  gps_pkg::dec_t      dec,
    output gps_pkg::out_item_t result
);

    logic [7:0] direction_reg, direction_next;
    logic [7:0] output_reg, output_next;
    logic [7:0] input_reg, input_next;
    logic [7:0] flag_reg, flag_next;
    logic [7:0] port_control_reg, port_control_next;
    logic [7:0] pin_control_reg [8];
    logic [7:0] pin_control_next [8];

    logic       is_read;
    logic       is_write;
    logic       is_pin;
    logic       mapped;
    logic [7:0] rd_value;
    logic [7:0] wd;
    logic [7:0] pin_bit;
    logic [2:0] sense;
    logic       changed;
    logic       hit;
    logic [7:0] pullups;

    assign is_read  = item.opcode == gps_pkg::OP_READ;
    assign is_write = item.opcode == gps_pkg::OP_WRITE;
    assign is_pin   = item.opcode == gps_pkg::OP_PIN;
    assign mapped   = dec.sel != gps_pkg::SEL_NONE;
    assign wd       = item.write_data;
    assign pin_bit  = 8'd1 << item.pin_index;

    // Read mux; aliases read back the base register
    always_comb
    begin
        case (dec.sel)
            gps_pkg::SEL_DIR, gps_pkg::SEL_DIRSET,
            gps_pkg::SEL_DIRCLR, gps_pkg::SEL_DIRTGL: rd_value = direction_reg;
            gps_pkg::SEL_OUT, gps_pkg::SEL_OUTSET,
            gps_pkg::SEL_OUTCLR, gps_pkg::SEL_OUTTGL: rd_value = output_reg;
            gps_pkg::SEL_IN:       rd_value = input_reg;
            gps_pkg::SEL_FLAGS:    rd_value = flag_reg;
            gps_pkg::SEL_PORTCTRL: rd_value = port_control_reg;
            gps_pkg::SEL_PINCTRL:  rd_value = pin_control_reg[dec.pin];
            default:               rd_value = 8'd0;
        endcase
    end

    // Pin change detection and sense decode
    assign changed = input_reg[item.pin_index] != item.pin_level;
    assign sense   = pin_control_reg[item.pin_index][2:0];

    always_comb
    begin
        case (sense)
            gps_pkg::SENSE_BOTH:    hit = 1'b1;
            gps_pkg::SENSE_RISING:  hit = item.pin_level;
            gps_pkg::SENSE_FALLING: hit = !item.pin_level;
            gps_pkg::SENSE_LOW:     hit = !item.pin_level;
            default:                hit = 1'b0;
        endcase
    end

    // Next state of every register
    always_comb
    begin
        direction_next    = direction_reg;
        output_next       = output_reg;
        input_next        = input_reg;
        flag_next         = flag_reg;
        port_control_next = port_control_reg;
        for (int i = 0; i < 8; i++)
            pin_control_next[i] = pin_control_reg[i];

        if (is_write)
        begin
            case (dec.sel)
                gps_pkg::SEL_DIR:      direction_next = wd;
                gps_pkg::SEL_DIRSET:   direction_next = direction_reg | wd;
                gps_pkg::SEL_DIRCLR:   direction_next = direction_reg & ~wd;
                gps_pkg::SEL_DIRTGL:   direction_next = direction_reg ^ wd;
                gps_pkg::SEL_OUT:      output_next = wd;
                gps_pkg::SEL_OUTSET:   output_next = output_reg | wd;
                gps_pkg::SEL_OUTCLR:   output_next = output_reg & ~wd;
                gps_pkg::SEL_OUTTGL:   output_next = output_reg ^ wd;
                gps_pkg::SEL_IN:       input_next = wd;
                gps_pkg::SEL_FLAGS:    flag_next = flag_reg & ~wd;
                gps_pkg::SEL_PORTCTRL: port_control_next = wd;
                gps_pkg::SEL_PINCTRL:  pin_control_next[dec.pin] = wd;
                default:               ;
            endcase
        end
        else if (is_pin && changed)
        begin
            input_next = item.pin_level ? (input_reg | pin_bit) : (input_reg & ~pin_bit);
            if (hit)
                flag_next = flag_reg | pin_bit;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= 8'd0;
            output_reg       <= 8'd0;
            input_reg        <= 8'd0;
            flag_reg         <= 8'd0;
            port_control_reg <= 8'd0;
            for (int i = 0; i < 8; i++)
                pin_control_reg[i] <= 8'd0;
        end
        else if (fire)
        begin
            direction_reg    <= direction_next;
            output_reg       <= output_next;
            input_reg        <= input_next;
            flag_reg         <= flag_next;
            port_control_reg <= port_control_next;
            for (int i = 0; i < 8; i++)
                pin_control_reg[i] <= pin_control_next[i];
        end
    end

    // Pull-up enables from the updated pin controls
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            pullups[i] = pin_control_next[i][gps_pkg::PULLUP_BIT];
    end

    // Result of this transaction
    always_comb
    begin
        result.read_data      = (is_read && mapped) ? rd_value : 8'd0;
        result.drive_value    = output_next;
        result.direction_mask = direction_next;
        result.pullup_mask    = pullups;
        result.irq            = flag_next != 8'd0;
        result.access_error   = (is_read || is_write) && !mapped;
    end

    // A pin event never clears a flag
    a_pin_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_pin |=> (flag_reg & $past(flag_reg)) == $past(flag_reg))
        else $error("pin event cleared an interrupt flag");

    // A pin event changes at most one input bit
    a_pin_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_pin |=> $countones(input_reg ^ $past(input_reg)) <= 1)
        else $error("pin event changed more than one input bit");

    // State holds when no transaction is taken
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(direction_reg) && $stable(output_reg) && $stable(flag_reg)
                  && $stable(input_reg))
        else $error("port state changed without a transaction");

    // Access errors come only from bus transactions
    a_err_bus_only: assert property (@(posedge clk) disable iff (!rst_n)
        result.access_error |-> (is_read || is_write))
        else $error("access error on a non-bus transaction");

endmodule

// ===== design/gpio_port_with_pin_sense.sv =====
// ----------------------------------------------------------------------------
// gpio_port_with_pin_sense
// 8-pin I/O port with set/clear/toggle aliases and pin change interrupts.
// ----------------------------------------------------------------------------
//  channel  | signals                        | payload
//  ---------+--------------------------------+----------------------
//  input    | in_valid / in_ready / in_item  | gps_pkg::in_item_t
//  output   | out_valid / out_ready / out_item | gps_pkg::out_item_t
//  config   | cfg_we / cfg_wdata             | base address, 16 bits
//
// One transaction per cycle while the output is not stalled; a transaction passes
// the input register, then the register file update and the result register in one pass.
// Reset clears all port registers and sets the base address to 0x0400.
// A stalled output holds its result; a full input register then holds too, and
// in_ready stays low until the output is taken.
// ----------------------------------------------------------------------------
module gpio_port_with_pin_sense (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gps_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output gps_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);

    logic               s1_valid_reg;
    gps_pkg::in_item_t  s1_item_reg;
    logic               out_valid_reg;
    gps_pkg::out_item_t out_item_reg;
    logic [15:0]        base_reg;

    logic               s1_fire;
    gps_pkg::dec_t      dec;
    gps_pkg::out_item_t result;

    // Stage advance whenever the result register is free or being emptied
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    // Base address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= gps_pkg::BASE_RESET;
        else if (cfg_we)
            base_reg <= cfg_wdata;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_item_reg <= in_item;
    end

    // Address decode
    gps_decode u_decode (
        .base_address (base_reg),
        .bus_address  (s1_item_reg.bus_address),
        .dec          (dec)
    );

    // Register file
    gps_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_fire),
        .item   (s1_item_reg),
        .dec    (dec),
        .result (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
